@@ rtl/core/pcnf_pkg.sv @@
// Shared types, constants and the per-axis minimum-image function
// for the periodic cutoff neighbour filter. No dependencies.
package pcnf_pkg;

    localparam int MAX_NEIGHBOURS = 64;
    localparam int MAX_PARTICLES  = 4096;
    localparam int COORD_W        = 24;
    localparam int INDEX_W        = 12;
    localparam int DIST_W         = 48;
    localparam int SQ_W           = 47;
    localparam int SLOT_W         = 6;
    localparam int COUNT_W        = 7;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_BOX_LEN_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOX_LEN_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOX_LEN_Z = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_SQ = 3'd3;

    localparam logic signed [25:0] DISP_MAX = 26'sd8388607;
    localparam logic signed [25:0] DISP_MIN = -26'sd8388608;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_box;

    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
        logic                      self_pair;
        logic [INDEX_W-1:0]        cand_index;
        logic                      last;
    } t_front_item;

    typedef struct packed {
        logic                      nb_stored;
        logic [INDEX_W-1:0]        neighbour_index;
        logic signed [COORD_W-1:0] disp_x;
        logic signed [COORD_W-1:0] disp_y;
        logic signed [COORD_W-1:0] disp_z;
        logic [DIST_W-1:0]         dist_sq;
        logic [SLOT_W-1:0]         list_slot;
        logic                      list_full;
        logic                      query_done;
        logic [COUNT_W-1:0]        list_count;
    } t_result;

    // ref minus cand, one wrap by the box length, saturated to 24 bits
    function automatic logic signed [COORD_W-1:0] wrap_axis(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic [COORD_W-1:0] len
    );
        logic signed [25:0] d;
        logic signed [25:0] l;
        logic signed [25:0] w;
        logic signed [26:0] d2;
        logic signed [26:0] l2;
        d  = $signed({2'b00, r}) - $signed({2'b00, c});
        l  = $signed({2'b00, len});
        d2 = {d, 1'b0};
        l2 = {l[25], l};
        if (d2 > l2) begin
            w = d - l;
        end else if (d2 < -l2) begin
            w = d + l;
        end else begin
            w = d;
        end
        if (w > DISP_MAX) begin
            w = DISP_MAX;
        end else if (w < DISP_MIN) begin
            w = DISP_MIN;
        end
        return w[COORD_W-1:0];
    endfunction

endpackage

@@ rtl/core/pcnf_front.sv @@
// Front end: accepts a pair, wraps the three displacements and flags the
// self pair, holding the classified item in one register. Uses pcnf_pkg.
module pcnf_front
    import pcnf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_box               i_box,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_ref_x,
    input  logic [COORD_W-1:0] i_ref_y,
    input  logic [COORD_W-1:0] i_ref_z,
    input  logic [INDEX_W-1:0] i_ref_index,
    input  logic [COORD_W-1:0] i_cand_x,
    input  logic [COORD_W-1:0] i_cand_y,
    input  logic [COORD_W-1:0] i_cand_z,
    input  logic [INDEX_W-1:0] i_cand_index,
    input  logic               i_last_candidate,
    output logic               o_valid,
    output t_front_item        o_item,
    input  logic               i_ready
);

    logic        r_valid;
    t_front_item r_item;
    t_front_item n_item;
    logic        take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_item.dx         = wrap_axis(i_ref_x, i_cand_x, i_box.x);
        n_item.dy         = wrap_axis(i_ref_y, i_cand_y, i_box.y);
        n_item.dz         = wrap_axis(i_ref_z, i_cand_z, i_box.z);
        n_item.self_pair  = (i_ref_index == i_cand_index);
        n_item.cand_index = i_cand_index;
        n_item.last       = i_last_candidate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/pcnf_queue.sv @@
// Two-entry queue of classified pairs between front and back end.
// Uses pcnf_pkg.
module pcnf_queue
    import pcnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_front_item i_item,
    output logic        o_ready,
    output logic        o_valid,
    output t_front_item o_item,
    input  logic        i_ready
);

    t_front_item r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic        wr;
    logic        rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr) begin
                r_wptr <= !r_wptr;
            end
            if (rd) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

@@ rtl/core/pcnf_back.sv @@
// Back end: squares the displacements, sums and compares with the cutoff,
// assigns list slots and queues results for the output. Uses pcnf_pkg.
module pcnf_back
    import pcnf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIST_W-1:0] i_cutoff_sq,
    input  logic              i_valid,
    input  t_front_item       i_item,
    output logic              o_ready,
    output logic              o_empty,
    output t_result           o_result,
    input  logic              i_pop
);

    logic               r_s1_valid;
    t_front_item        r_s1_item;
    logic [SQ_W-1:0]    r_sq_x;
    logic [SQ_W-1:0]    r_sq_y;
    logic [SQ_W-1:0]    r_sq_z;
    logic signed [2*COORD_W-1:0] prod_x;
    logic signed [2*COORD_W-1:0] prod_y;
    logic signed [2*COORD_W-1:0] prod_z;

    logic [COUNT_W-1:0] r_hit_count;
    logic [COUNT_W-1:0] n_hit_count;
    t_result            n_result;
    logic [DIST_W-1:0]  sum;
    logic               hit;

    t_result            r_mem [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    logic               out_ready;
    logic               push;
    logic               rd;

    assign out_ready = (r_cnt != 2'd2);
    assign push      = r_s1_valid && out_ready;
    assign rd        = (r_cnt != 2'd0) && i_pop;
    assign o_ready   = !r_s1_valid || out_ready;

    assign prod_x = i_item.dx * i_item.dx;
    assign prod_y = i_item.dy * i_item.dy;
    assign prod_z = i_item.dz * i_item.dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_s1_item <= i_item;
            r_sq_x    <= prod_x[SQ_W-1:0];
            r_sq_y    <= prod_y[SQ_W-1:0];
            r_sq_z    <= prod_z[SQ_W-1:0];
        end
    end

    always_comb begin
        sum = {1'b0, r_sq_x} + {1'b0, r_sq_y} + {1'b0, r_sq_z};
        hit = (sum <= i_cutoff_sq) && !r_s1_item.self_pair;
        n_hit_count              = r_hit_count;
        n_result.nb_stored       = 1'b0;
        n_result.list_slot       = '0;
        n_result.list_full       = 1'b0;
        if (hit) begin
            if (r_hit_count < COUNT_W'(MAX_NEIGHBOURS)) begin
                n_result.nb_stored    = 1'b1;
                n_result.list_slot    = r_hit_count[SLOT_W-1:0];
                n_hit_count           = r_hit_count + 1'b1;
            end else begin
                n_result.list_full    = 1'b1;
            end
        end
        n_result.neighbour_index = r_s1_item.cand_index;
        n_result.disp_x          = r_s1_item.dx;
        n_result.disp_y          = r_s1_item.dy;
        n_result.disp_z          = r_s1_item.dz;
        n_result.dist_sq         = sum;
        n_result.query_done      = r_s1_item.last;
        n_result.list_count      = n_hit_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count <= '0;
            r_wptr      <= 1'b0;
            r_rptr      <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (push) begin
                r_hit_count <= r_s1_item.last ? '0 : n_hit_count;
                r_wptr      <= !r_wptr;
            end
            if (rd) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, rd};
        end
        if (push) begin
            r_mem[r_wptr] <= n_result;
        end
    end

    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_count <= COUNT_W'(MAX_NEIGHBOURS))
        else $error("hit count beyond list size");

    a_clear_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_s1_item.last |=> r_hit_count == '0)
        else $error("hit count not cleared after last candidate");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && n_result.nb_stored && !r_s1_item.last
        |=> r_hit_count == $past(r_hit_count) + 1'b1)
        else $error("hit count did not advance on a hit");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && n_result.list_full |-> r_hit_count == COUNT_W'(MAX_NEIGHBOURS))
        else $error("list full flagged with free slots");

endmodule

@@ rtl/core/periodic_cutoff_neighbour_filter_top.sv @@
// Top level of the periodic cutoff neighbour filter: configuration
// registers, front end, pair queue and back end. Uses pcnf_pkg.
//
// Each pair (reference, candidate) pushed in gives exactly one result, in
// order. The block takes one pair per cycle sustained while results are
// popped as they come; a result reaches the output through the front
// register, pair queue, squarer register, then the result queue; the three
// 24x24 squarers in the back end sit behind their own register. Box
// lengths and the squared cutoff are written through the cfg channel,
// which is always ready; write only while no pair is in flight. Register
// index 0..2 is the box length in x, y, z, index 3 the squared cutoff;
// other indexes are ignored.
module periodic_cutoff_neighbour_filter_top
    import pcnf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [COORD_W-1:0]     i_ref_x,
    input  logic [COORD_W-1:0]     i_ref_y,
    input  logic [COORD_W-1:0]     i_ref_z,
    input  logic [INDEX_W-1:0]     i_ref_index,
    input  logic [COORD_W-1:0]     i_cand_x,
    input  logic [COORD_W-1:0]     i_cand_y,
    input  logic [COORD_W-1:0]     i_cand_z,
    input  logic [INDEX_W-1:0]     i_cand_index,
    input  logic                   i_last_candidate,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_nb_stored,
    output logic [INDEX_W-1:0]     o_neighbour_index,
    output logic signed [COORD_W-1:0] o_disp_x,
    output logic signed [COORD_W-1:0] o_disp_y,
    output logic signed [COORD_W-1:0] o_disp_z,
    output logic [DIST_W-1:0]      o_dist_sq,
    output logic [SLOT_W-1:0]      o_list_slot,
    output logic                   o_list_full,
    output logic                   o_query_done,
    output logic [COUNT_W-1:0]     o_list_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_box              r_box;
    logic [DIST_W-1:0] r_cutoff_sq;

    logic              front_ready;
    logic              front_valid;
    t_front_item       front_item;
    logic              q_ready;
    logic              q_valid;
    t_front_item       q_item;
    logic              back_ready;
    t_result           result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.x     <= '1;
            r_box.y     <= '1;
            r_box.z     <= '1;
            r_cutoff_sq <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BOX_LEN_X: r_box.x     <= i_cfg_data[COORD_W-1:0];
                CFG_BOX_LEN_Y: r_box.y     <= i_cfg_data[COORD_W-1:0];
                CFG_BOX_LEN_Z: r_box.z     <= i_cfg_data[COORD_W-1:0];
                CFG_CUTOFF_SQ: r_cutoff_sq <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign full = !front_ready;

    pcnf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_box            (r_box),
        .i_valid          (push),
        .o_ready          (front_ready),
        .i_ref_x          (i_ref_x),
        .i_ref_y          (i_ref_y),
        .i_ref_z          (i_ref_z),
        .i_ref_index      (i_ref_index),
        .i_cand_x         (i_cand_x),
        .i_cand_y         (i_cand_y),
        .i_cand_z         (i_cand_z),
        .i_cand_index     (i_cand_index),
        .i_last_candidate (i_last_candidate),
        .o_valid          (front_valid),
        .o_item           (front_item),
        .i_ready          (q_ready)
    );

    pcnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (back_ready)
    );

    pcnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cutoff_sq (r_cutoff_sq),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_ready     (back_ready),
        .o_empty     (empty),
        .o_result    (result),
        .i_pop       (pop)
    );

    assign o_nb_stored       = result.nb_stored;
    assign o_neighbour_index = result.neighbour_index;
    assign o_disp_x          = result.disp_x;
    assign o_disp_y          = result.disp_y;
    assign o_disp_z          = result.disp_z;
    assign o_dist_sq         = result.dist_sq;
    assign o_list_slot       = result.list_slot;
    assign o_list_full       = result.list_full;
    assign o_query_done      = result.query_done;
    assign o_list_count      = result.list_count;

endmodule
